### hw/rtl/pfa_pkg.sv
// Shared types, codes and widths of the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

  // Default sizes for the top level parameters
  localparam int MAX_FRAMES_DEF     = 64;
  localparam int MAX_PAGE_WORDS_DEF = 4096;

  // Field widths
  localparam int WORD_W      = 19;
  localparam int FRAME_W     = 6;
  localparam int PAGE_W      = 13;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int FRAME_SLOTS = 1 << FRAME_W;

  // Divider sizing: quotient never exceeds the frame count (at most 64)
  localparam int REM_W  = WORD_W + 1;
  localparam int QUO_W  = 7;
  localparam int STEP_W = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_WORDS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 1'b1;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Classified request handed from front to back
  typedef enum logic [2:0] {
    CMD_FREE_OK,
    CMD_FREE_BAD,
    CMD_ALLOC_EMPTY,
    CMD_ALLOC_REJECT,
    CMD_ALLOC_RUN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [WORD_W-1:0]   word_count;
    logic [FRAME_W-1:0]  frame_index;
    logic                batch_end;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                has_frame;
    logic [FRAME_W-1:0]  frame_out;
    logic                last;
  } result_t;

endpackage

### hw/rtl/pfa_fifo.sv
// Small register queue used for the command and result queues.
`timescale 1ns / 1ps

module pfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] used;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (used == CNT_W'(DEPTH));
  assign empty   = (used == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        used <= used + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        used <= used - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/pfa_front.sv
// Request front end: takes items, classifies them and queues commands.
`timescale 1ns / 1ps

module pfa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           op,
  input  logic [pfa_pkg::WORD_W-1:0]     word_count,
  input  logic [pfa_pkg::FRAME_W-1:0]    frame_index,
  input  logic                           batch_end,
  input  logic [pfa_pkg::PAGE_W-1:0]     pw_eff,
  input  logic [pfa_pkg::COUNT_W-1:0]    nf_eff,
  input  logic                           cmd_full,
  output logic                           cmd_push,
  output pfa_pkg::cmd_t                  cmd
);

  import pfa_pkg::*;

  logic               held_valid;
  logic               held_op;
  logic [WORD_W-1:0]  held_words;
  logic [FRAME_W-1:0] held_index;
  logic               held_bend;
  logic [REM_W-1:0]   limit;
  logic               accept;

  assign full     = held_valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = held_valid && !cmd_full;

  // Track the memory size in words; config must only change while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    limit <= REM_W'(nf_eff) * REM_W'(pw_eff);
  end

  // Hold the accepted item until the command queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (cmd_push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op    <= op;
      held_words <= word_count;
      held_index <= frame_index;
      held_bend  <= batch_end;
    end
  end

  // Classify the held item
  always_comb begin
    cmd.word_count  = held_words;
    cmd.frame_index = held_index;
    cmd.batch_end   = held_bend;
    if (held_op == OP_FREE) begin
      cmd.kind = (COUNT_W'(held_index) >= nf_eff) ? CMD_FREE_BAD : CMD_FREE_OK;
    end else if (REM_W'(held_words) > limit) begin
      cmd.kind = CMD_ALLOC_REJECT;
    end else if (held_words == '0) begin
      cmd.kind = CMD_ALLOC_EMPTY;
    end else begin
      cmd.kind = CMD_ALLOC_RUN;
    end
  end

endmodule

### hw/rtl/pfa_back.sv
// Command back end: owns the frame map, divides, counts and grants frames.
`timescale 1ns / 1ps

module pfa_back #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_empty,
  input  pfa_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  input  logic [pfa_pkg::PAGE_W-1:0]     pw_eff,
  input  logic [pfa_pkg::COUNT_W-1:0]    nf_eff,
  input  logic                           res_full,
  output logic                           res_push,
  output pfa_pkg::result_t               res
);

  import pfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_COUNT = 5'b00100,
    S_GRANT = 5'b01000,
    S_FAIL  = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [MAX_FRAMES-1:0]  free_map;
  logic [FRAME_SLOTS-1:0] map_ext;
  logic [FRAME_SLOTS-1:0] map_next;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_next;
  logic [REM_W-1:0]       shifted;
  logic [QUO_W-1:0]       need;
  logic [QUO_W-1:0]       need_next;
  logic [STEP_W-1:0]      step;
  logic [STEP_W-1:0]      step_next;
  logic [COUNT_W-1:0]     idx;
  logic [COUNT_W-1:0]     idx_next;
  logic [COUNT_W-1:0]     tally;
  logic [COUNT_W-1:0]     tally_next;
  logic                   map_bit;
  logic                   reach;

  assign map_ext = FRAME_SLOTS'(free_map);
  assign map_bit = map_ext[idx[FRAME_W-1:0]];
  assign shifted = REM_W'(pw_eff) << step;
  assign reach   = ((tally + COUNT_W'(1)) == COUNT_W'(need));

  // Sequence one command at a time
  always_comb begin
    state_next = state;
    map_next   = map_ext;
    rem_next   = rem;
    need_next  = need;
    step_next  = step;
    idx_next   = idx;
    tally_next = tally;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res.status    = ST_OK;
    res.has_frame = 1'b0;
    res.frame_out = '0;
    res.last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            CMD_FREE_OK: begin
              if (!res_full) begin
                cmd_pop   = 1'b1;
                res_push  = 1'b1;
                res.last  = cmd.batch_end;
                map_next[cmd.frame_index] = 1'b1;
              end
            end
            CMD_FREE_BAD: begin
              if (!res_full) begin
                cmd_pop    = 1'b1;
                res_push   = 1'b1;
                res.status = ST_BAD_INDEX;
                res.last   = cmd.batch_end;
              end
            end
            CMD_ALLOC_EMPTY: begin
              if (!res_full) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
              end
            end
            CMD_ALLOC_REJECT: begin
              if (!res_full) begin
                cmd_pop    = 1'b1;
                res_push   = 1'b1;
                res.status = ST_NO_MEM;
              end
            end
            CMD_ALLOC_RUN: begin
              // Round up: divide word_count + page_words - 1
              cmd_pop    = 1'b1;
              rem_next   = REM_W'(cmd.word_count) + REM_W'(pw_eff) - REM_W'(1);
              need_next  = '0;
              step_next  = STEP_W'(QUO_W - 1);
              state_next = S_DIV;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end

      S_DIV: begin
        // One quotient bit per cycle, high bit first
        if (rem >= shifted) begin
          rem_next        = rem - shifted;
          need_next[step] = 1'b1;
        end
        if (step == '0) begin
          state_next = S_COUNT;
          idx_next   = '0;
          tally_next = '0;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end

      S_COUNT: begin
        // Walk the map until enough free frames are seen or the frame count runs out
        if (map_bit && reach) begin
          state_next = S_GRANT;
          idx_next   = '0;
          tally_next = '0;
        end else if (idx == nf_eff - COUNT_W'(1)) begin
          state_next = S_FAIL;
        end else begin
          idx_next   = idx + COUNT_W'(1);
          tally_next = tally + COUNT_W'(map_bit);
        end
      end

      S_GRANT: begin
        // Hand out the lowest free frames in order
        if (map_bit) begin
          if (!res_full) begin
            res_push      = 1'b1;
            res.has_frame = 1'b1;
            res.frame_out = idx[FRAME_W-1:0];
            res.last      = reach;
            map_next[idx[FRAME_W-1:0]] = 1'b0;
            idx_next   = idx + COUNT_W'(1);
            tally_next = tally + COUNT_W'(1);
            if (reach) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          idx_next = idx + COUNT_W'(1);
        end
      end

      S_FAIL: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.status = ST_NO_MEM;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      free_map <= '1;
    end else begin
      state    <= state_next;
      free_map <= MAX_FRAMES'(map_next);
    end
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    need  <= need_next;
    step  <= step_next;
    idx   <= idx_next;
    tally <= tally_next;
  end

  // Frame need after division is nonzero and fits the frame count
  a_need_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == '0) |=> (need != '0 && COUNT_W'(need) <= nf_eff))
    else $error("frame need out of range after division");

  // Counting and granting never pass the frame need
  a_tally_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT || state == S_GRANT) |-> (tally < COUNT_W'(need)))
    else $error("tally reached need without leaving scan");

  // Each grant takes exactly one frame out of the free map
  a_grant_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT && res_push) |=>
      ($countones(free_map) == $past($countones(free_map)) - 1))
    else $error("grant did not clear exactly one frame");

endmodule

### hw/rtl/page_frame_allocator_unit.sv
// Top level of the first-fit page frame allocator.
// Path: a free passes the front end hold register, the command queue and
//   the result queue; an allocate also passes the divider, a count scan and,
//   if enough frames are free, a grant scan of the frame map.
// Throughput: frees sustain one item per cycle while results are popped; an
//   allocate holds the back end for its divide and up to two map scans.
// Reset: synchronous; every frame free, page_words 16, frame_count 64.
`timescale 1ns / 1ps

module page_frame_allocator_unit #(
  parameter int MAX_FRAMES     = pfa_pkg::MAX_FRAMES_DEF,
  parameter int MAX_PAGE_WORDS = pfa_pkg::MAX_PAGE_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_write,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Requests
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic [pfa_pkg::WORD_W-1:0]          word_count,
  input  logic [pfa_pkg::FRAME_W-1:0]         frame_index,
  input  logic                                batch_end,
  // Results
  output logic                                empty,
  input  logic                                pop,
  output logic [pfa_pkg::STATUS_W-1:0]        status,
  output logic                                has_frame,
  output logic [pfa_pkg::FRAME_W-1:0]         frame_out,
  output logic                                last
);

  import pfa_pkg::*;

  localparam int PAGE_MAX = (1 << PAGE_W) - 1;
  localparam int PW_CAP   = (MAX_PAGE_WORDS > PAGE_MAX) ? PAGE_MAX : MAX_PAGE_WORDS;

  logic [PAGE_W-1:0]  page_words;
  logic [COUNT_W-1:0] frame_count;
  logic [PAGE_W-1:0]  pw_eff;
  logic [COUNT_W-1:0] nf_eff;

  cmd_t    cmd_in;
  cmd_t    cmd_head;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_pop;
  logic    cmd_empty;
  result_t res_in;
  result_t res_head;
  logic    res_push;
  logic    res_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_words  <= PAGE_W'(16);
      frame_count <= COUNT_W'(64);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PAGE_WORDS:  page_words  <= cfg_data[PAGE_W-1:0];
        CFG_FRAME_COUNT: frame_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values to the legal ranges
  always_comb begin
    priority if (page_words == '0) begin
      pw_eff = PAGE_W'(1);
    end else if (32'(page_words) > 32'(PW_CAP)) begin
      pw_eff = PAGE_W'(PW_CAP);
    end else begin
      pw_eff = page_words;
    end
    priority if (frame_count == '0) begin
      nf_eff = COUNT_W'(1);
    end else if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      nf_eff = COUNT_W'(MAX_FRAMES);
    end else begin
      nf_eff = frame_count;
    end
  end

  pfa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .word_count  (word_count),
    .frame_index (frame_index),
    .batch_end   (batch_end),
    .pw_eff      (pw_eff),
    .nf_eff      (nf_eff),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  pfa_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  pfa_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pw_eff    (pw_eff),
    .nf_eff    (nf_eff),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  pfa_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  // Present the oldest result
  assign status    = res_head.status;
  assign has_frame = res_head.has_frame;
  assign frame_out = res_head.frame_out;
  assign last      = res_head.last;

endmodule
